### sv/size_bucket_histogram_defines.svh
// ----------------------------------------------------------------------------
// size_bucket_histogram_defines.svh
// Assertion macros used by the size bucket histogram module.
// ----------------------------------------------------------------------------
`ifndef SIZE_BUCKET_HISTOGRAM_DEFINES_SVH
`define SIZE_BUCKET_HISTOGRAM_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SBH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sbh_pkg.sv
// ----------------------------------------------------------------------------
// sbh_pkg
// Types, constants and the bucket lower-bound function of the size histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package sbh_pkg;

	localparam int SIZE_W = 31;
	localparam int BKT_W  = 5;
	localparam int CNT_W  = 32;

	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [BKT_W-1:0]  bkt_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam size_t SMALL_LIMIT   = 31'd1024;
	localparam size_t MID_LIMIT     = 31'd20480;
	localparam size_t LARGE_LIMIT   = 31'd40960;
	localparam size_t LOG_BASE_SIZE = 31'd65536;

	localparam bkt_t SMALL_END_BKT = 5'd2;
	localparam bkt_t MID_BASE_BKT  = 5'd11;
	localparam bkt_t MID_END_BKT   = 5'd12;
	localparam bkt_t LOG_BASE_BKT  = 5'd17;

	// lowest byte size that lands in bucket i
	function automatic size_t bucket_low(input bkt_t i);
		bkt_t  off;
		size_t lb;
		off = '0;
		if (i < SMALL_END_BKT) begin
			lb = size_t'(i) << 10;
		end else if (i < MID_END_BKT) begin
			off = i - 5'd1;
			lb  = size_t'(off) << 11;
		end else if (i < LOG_BASE_BKT) begin
			off = i - MID_BASE_BKT;
			lb  = (size_t'(off) << 12) + MID_LIMIT;
		end else begin
			off = i - LOG_BASE_BKT;
			lb  = LOG_BASE_SIZE << off[3:0];
		end
		return lb;
	endfunction

endpackage

`default_nettype wire

### sv/size_bucket_histogram.sv
// ----------------------------------------------------------------------------
// size_bucket_histogram
// Histogram of entry sizes kept in NUM_BUCKETS wrapping 32-bit counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per command. An update
//   (command 0) adds one to the bucket of a nonzero next_size and removes one
//   from the bucket of a nonzero prev_size; its result beat reports both
//   buckets. A read (command 1) returns the count of bucket_index (saturated
//   to the last bucket), negative counts shown as zero, plus the bucket's
//   lowest byte size.
//   Output channel (out_valid/out_ready) carries one result beat per command,
//   in order.
//   Path: each input beat passes the input register, then the result
//   register. Throughput: one beat per cycle while out_ready is high;
//   counters are updated in place, so a read right after an update sees it.
//   Reset: all counters clear at once, both stages empty, no sweep.
//   Stall: a held result keeps its beat; the input register still takes one
//   more beat, then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none
`include "size_bucket_histogram_defines.svh"

module size_bucket_histogram #(
	parameter int NUM_BUCKETS = 28
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  command,
	input  wire sbh_pkg::size_t  prev_size,
	input  wire sbh_pkg::size_t  next_size,
	input  wire sbh_pkg::bkt_t   bucket_index,
	output logic                 out_valid,
	input  wire                  out_ready,
	output sbh_pkg::bkt_t        new_bucket,
	output sbh_pkg::bkt_t        old_bucket,
	output sbh_pkg::size_t       bucket_count,
	output sbh_pkg::size_t       bucket_low_bound
);

	localparam int IdxW = $clog2(NUM_BUCKETS);
	localparam logic [5:0] LastBkt = 6'(NUM_BUCKETS - 1);

	// stage 1: input register
	logic           valid_s1;
	logic           cmd_s1;
	sbh_pkg::size_t old_s1;
	sbh_pkg::size_t new_s1;
	sbh_pkg::bkt_t  idx_s1;

	// stage 2: result register
	logic           valid_s2;
	sbh_pkg::bkt_t  nb_s2;
	sbh_pkg::bkt_t  ob_s2;
	sbh_pkg::size_t cnt_s2;
	sbh_pkg::size_t low_s2;

	logic [NUM_BUCKETS-1:0][sbh_pkg::CNT_W-1:0] cnt_q;

	logic              adv_s1;
	logic              is_upd;
	sbh_pkg::bkt_t     nb;
	sbh_pkg::bkt_t     ob;
	logic [IdxW-1:0]   rd_idx;
	sbh_pkg::bkt_t     rd_bkt;
	sbh_pkg::cnt_t     rd_cnt;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign is_upd   = (cmd_s1 == sbh_pkg::CMD_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= command;
			old_s1 <= prev_size;
			new_s1 <= next_size;
			idx_s1 <= bucket_index;
		end
	end

	sbh_bucket_map #(.NUM_BUCKETS(NUM_BUCKETS)) u_map_new (
		.size   (new_s1),
		.bucket (nb)
	);

	sbh_bucket_map #(.NUM_BUCKETS(NUM_BUCKETS)) u_map_old (
		.size   (old_s1),
		.bucket (ob)
	);

	// per-bucket in-place counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv_s1 && is_upd) begin
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				case ({new_s1 != '0 && nb == 5'(i), old_s1 != '0 && ob == 5'(i)})
					2'b10:   cnt_q[i] <= cnt_q[i] + 32'd1;
					2'b01:   cnt_q[i] <= cnt_q[i] - 32'd1;
					default: cnt_q[i] <= cnt_q[i];
				endcase
			end
		end
	end

	assign rd_idx = ({1'b0, idx_s1} >= LastBkt) ? LastBkt[IdxW-1:0] : idx_s1[IdxW-1:0];
	assign rd_bkt = 5'(rd_idx);
	assign rd_cnt = cnt_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			if (is_upd) begin
				nb_s2  <= nb;
				ob_s2  <= ob;
				cnt_s2 <= '0;
				low_s2 <= '0;
			end else begin
				nb_s2  <= '0;
				ob_s2  <= '0;
				cnt_s2 <= rd_cnt[31] ? '0 : rd_cnt[30:0];
				low_s2 <= sbh_pkg::bucket_low(rd_bkt);
			end
		end
	end

	assign out_valid        = valid_s2;
	assign new_bucket       = nb_s2;
	assign old_bucket       = ob_s2;
	assign bucket_count     = cnt_s2;
	assign bucket_low_bound = low_s2;

	`SBH_ASSERT_NOW(a_bkt_range, clk, arst_n, out_valid,
		{1'b0, new_bucket} <= LastBkt && {1'b0, old_bucket} <= LastBkt,
		"bucket beyond last")
	`SBH_ASSERT_NOW(a_upd_zero, clk, arst_n, out_valid && (new_bucket != '0 || old_bucket != '0),
		bucket_count == '0 && bucket_low_bound == '0, "update beat carries read data")
	`SBH_ASSERT_NEXT(a_cnt_hold, clk, arst_n, !(adv_s1 && is_upd), $stable(cnt_q),
		"counters changed without an update")
	`SBH_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv_s1, valid_s1 && $stable(new_s1),
		"stalled stage 1 lost its beat")

endmodule

`default_nettype wire

### sv/sbh_bucket_map.sv
// ----------------------------------------------------------------------------
// sbh_bucket_map
// Maps a byte size to its histogram bucket: linear ranges, then log2.
// ----------------------------------------------------------------------------
`default_nettype none

module sbh_bucket_map #(
	parameter int NUM_BUCKETS = 28
) (
	input  wire sbh_pkg::size_t size,
	output sbh_pkg::bkt_t       bucket
);

	localparam logic [5:0] LastBkt = 6'(NUM_BUCKETS - 1);

	sbh_pkg::bkt_t  msb;
	sbh_pkg::size_t mid_off;
	logic [5:0]     log_bkt;

	// priority encode the top set bit
	always_comb begin
		msb = '0;
		for (int b = 1; b < sbh_pkg::SIZE_W; b++) begin
			if (size[b]) begin
				msb = 5'(b);
			end
		end
	end

	assign mid_off = size - sbh_pkg::MID_LIMIT;
	assign log_bkt = {1'b0, msb} + 6'd1;

	always_comb begin
		if (size < sbh_pkg::SMALL_LIMIT) begin
			bucket = '0;
		end else if (size < sbh_pkg::MID_LIMIT) begin
			bucket = {1'b0, size[14:11]} + 5'd1;
		end else if (size < sbh_pkg::LARGE_LIMIT) begin
			bucket = {2'b00, mid_off[14:12]} + sbh_pkg::MID_BASE_BKT;
		end else if (log_bkt >= LastBkt) begin
			bucket = LastBkt[4:0];
		end else begin
			bucket = log_bkt[4:0];
		end
	end

endmodule

`default_nettype wire

### test/size_bucket_histogram_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_bucket_histogram_checker
// Watches both channels of the size histogram, keeps its own copy of the
// bucket counters, works out the result of every accepted input beat and
// compares each result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module size_bucket_histogram_checker #(
	parameter int NUM_BUCKETS = 28
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  logic           command,
	input  sbh_pkg::size_t prev_size,
	input  sbh_pkg::size_t next_size,
	input  sbh_pkg::bkt_t  bucket_index,
	input  logic           out_valid,
	input  logic           out_ready,
	input  sbh_pkg::bkt_t  new_bucket,
	input  sbh_pkg::bkt_t  old_bucket,
	input  sbh_pkg::size_t bucket_count,
	input  sbh_pkg::size_t bucket_low_bound,
	output int             mismatches,
	output int             outstanding
);

	typedef struct packed {
		sbh_pkg::bkt_t  new_bkt;
		sbh_pkg::bkt_t  old_bkt;
		sbh_pkg::size_t count;
		sbh_pkg::size_t low_bound;
	} histo_result_t;

	sbh_pkg::cnt_t tally [NUM_BUCKETS];
	histo_result_t expected_results [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
		foreach (tally[i])
			tally[i] = '0;
	end

	function automatic int size_bucket_of(sbh_pkg::size_t s);
		int lg;
		lg = 0;
		if (s < 1024)
			return 0;
		if (s < 20 * 1024)
			return s / 2048 + 1;
		if (s < 40 * 1024)
			return (s - 20 * 1024) / 4096 + 11;
		for (int b = 0; b < sbh_pkg::SIZE_W; b++)
			if (s[b])
				lg = b;
		return (lg + 1 >= NUM_BUCKETS) ? NUM_BUCKETS - 1 : lg + 1;
	endfunction

	function automatic sbh_pkg::size_t bucket_floor_bytes(int i);
		if (i < 2)
			return sbh_pkg::size_t'(1024 * i);
		if (i < 12)
			return sbh_pkg::size_t'(2048 * (i - 1));
		if (i < 17)
			return sbh_pkg::size_t'(4096 * (i - 11) + 20 * 1024);
		return sbh_pkg::size_t'(65536) << ((i - 17) & 15);
	endfunction

	// advances the counter copy and returns the result beat
	function automatic histo_result_t apply_beat(logic cmd, sbh_pkg::size_t osz,
		sbh_pkg::size_t nsz, sbh_pkg::bkt_t idx);
		histo_result_t r;
		int nb, ob, sel;
		sbh_pkg::cnt_t c;
		r = '0;
		if (cmd == sbh_pkg::CMD_UPDATE) begin
			nb = size_bucket_of(nsz);
			ob = size_bucket_of(osz);
			if (nsz != 0)
				tally[nb] = tally[nb] + 1;
			if (osz != 0)
				tally[ob] = tally[ob] - 1;
			r.new_bkt = sbh_pkg::bkt_t'(nb);
			r.old_bkt = sbh_pkg::bkt_t'(ob);
		end else begin
			sel = (idx >= NUM_BUCKETS) ? NUM_BUCKETS - 1 : idx;
			c = tally[sel];
			r.count     = c[sbh_pkg::CNT_W-1] ? '0 : c[sbh_pkg::SIZE_W-1:0];
			r.low_bound = bucket_floor_bytes(sel);
		end
		return r;
	endfunction

	task automatic note_mismatch(string msg);
		$display("%0t ns: MISMATCH %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch
		histo_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					note_mismatch("result beat with no prediction outstanding");
				end else begin
					want = expected_results.pop_front();
					if (new_bucket !== want.new_bkt)
						note_mismatch($sformatf("new_bucket %0d, want %0d",
							new_bucket, want.new_bkt));
					if (old_bucket !== want.old_bkt)
						note_mismatch($sformatf("old_bucket %0d, want %0d",
							old_bucket, want.old_bkt));
					if (bucket_count !== want.count)
						note_mismatch($sformatf("bucket_count %0d, want %0d",
							bucket_count, want.count));
					if (bucket_low_bound !== want.low_bound)
						note_mismatch($sformatf("bucket_low_bound %0d, want %0d",
							bucket_low_bound, want.low_bound));
				end
			end
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					apply_beat(command, prev_size, next_size, bucket_index));
		end
		outstanding = expected_results.size();
	end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the size histogram: a directed pass over bucket boundaries,
// extreme sizes, cancelling updates, negative counts and oversized read
// indexes, then random add/remove traffic that mostly removes sizes added
// earlier, with random idle bursts on both channels and one long output
// stall. Prediction and checking live in the checker module.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_BUCKETS = 28;
	localparam int RANDOM_BEATS = 500;
	localparam int READ_PICKS [11] = '{0, 1, 2, 10, 11, 16, 17, 26, 27, 28, 31};

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	logic           command;
	sbh_pkg::size_t prev_size;
	sbh_pkg::size_t next_size;
	sbh_pkg::bkt_t  bucket_index;
	logic           out_valid;
	logic           out_ready;
	sbh_pkg::bkt_t  new_bucket;
	sbh_pkg::bkt_t  old_bucket;
	sbh_pkg::size_t bucket_count;
	sbh_pkg::size_t bucket_low_bound;

	int             mismatches;
	int             outstanding;
	bit             idling;
	bit             hold_req;
	sbh_pkg::size_t live_sizes [$];

	size_bucket_histogram #(.NUM_BUCKETS(NUM_BUCKETS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .prev_size(prev_size), .next_size(next_size),
		.bucket_index(bucket_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_bucket(new_bucket), .old_bucket(old_bucket),
		.bucket_count(bucket_count), .bucket_low_bound(bucket_low_bound)
	);

	size_bucket_histogram_checker #(.NUM_BUCKETS(NUM_BUCKETS)) histo_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .prev_size(prev_size), .next_size(next_size),
		.bucket_index(bucket_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_bucket(new_bucket), .old_bucket(old_bucket),
		.bucket_count(bucket_count), .bucket_low_bound(bucket_low_bound),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_beat(logic cmd, sbh_pkg::size_t osz, sbh_pkg::size_t nsz,
		sbh_pkg::bkt_t idx);
		if (idling && !hold_req && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		prev_size    <= osz;
		next_size    <= nsz;
		bucket_index <= idx;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic sbh_pkg::size_t pick_size();
		int sh;
		case ($urandom_range(0, 6))
			0: return '0;
			1: return sbh_pkg::size_t'($urandom_range(1, 1023));
			2: return sbh_pkg::size_t'($urandom_range(1024, 20 * 1024 - 1));
			3: return sbh_pkg::size_t'($urandom_range(20 * 1024, 40 * 1024 - 1));
			4: begin
				sh = $urandom_range(15, 30);
				return sbh_pkg::size_t'((32'd1 << sh) | ($urandom & ((32'd1 << sh) - 1)));
			end
			5: return sbh_pkg::size_t'($urandom);
			default: return sbh_pkg::size_t'($urandom_range(32'h0400_0000, 32'h7FFF_FFFF));
		endcase
	endfunction

	task automatic random_update();
		sbh_pkg::size_t nsz, osz;
		int k;
		nsz = pick_size();
		if (live_sizes.size() != 0 && $urandom_range(0, 3) != 0) begin
			k   = $urandom_range(0, live_sizes.size() - 1);
			osz = live_sizes[k];
			live_sizes.delete(k);
		end else begin
			osz = $urandom_range(0, 1) ? sbh_pkg::size_t'(0) : pick_size();
		end
		if (nsz != 0)
			live_sizes.insert(live_sizes.size(), nsz);
		send_beat(sbh_pkg::CMD_UPDATE, osz, nsz, sbh_pkg::bkt_t'($urandom));
	endtask

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (80) @(negedge clk);
				hold_req = 1'b0;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int w;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = sbh_pkg::CMD_UPDATE;
		prev_size    = '0;
		next_size    = '0;
		bucket_index = '0;
		idling       = 1'b1;
		hold_req     = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_beat(sbh_pkg::CMD_READ,   '0, '0, 5'd0);
		send_beat(sbh_pkg::CMD_UPDATE, '0, 31'd1, 5'd0);
		send_beat(sbh_pkg::CMD_UPDATE, 31'd1024, 31'd1023, 5'd0);
		send_beat(sbh_pkg::CMD_READ,   '0, '0, 5'd1);                 // negative count
		send_beat(sbh_pkg::CMD_UPDATE, '0, 31'd1024, 5'd0);
		send_beat(sbh_pkg::CMD_UPDATE, 31'd20479, 31'd2048, 5'd0);
		send_beat(sbh_pkg::CMD_UPDATE, 31'd40959, 31'd20480, 5'd0);
		send_beat(sbh_pkg::CMD_UPDATE, 31'd65535, 31'd40960, 5'd0);   // same bucket
		send_beat(sbh_pkg::CMD_UPDATE, 31'h7FFF_FFFF, 31'd65536, 5'd0);
		send_beat(sbh_pkg::CMD_UPDATE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 5'd31);
		send_beat(sbh_pkg::CMD_UPDATE, 31'h0400_0000, 31'h03FF_FFFF, 5'd0);
		send_beat(sbh_pkg::CMD_UPDATE, '0, '0, 5'd0);
		send_beat(sbh_pkg::CMD_UPDATE, 31'h2AAA_AAAA, 31'h5555_5555, 5'd21);
		foreach (READ_PICKS[i])
			send_beat(sbh_pkg::CMD_READ, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
				sbh_pkg::bkt_t'(READ_PICKS[i]));

		hold_req = 1'b1;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n == RANDOM_BEATS - 100)
				idling = 1'b0;
			if ($urandom_range(0, 9) < 3)
				send_beat(sbh_pkg::CMD_READ, pick_size(), pick_size(),
					sbh_pkg::bkt_t'($urandom));
			else
				random_update();
		end
		in_valid <= 1'b0;

		for (w = 0; w < 4000 && outstanding != 0; w++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/sbh_pkg.sv
sv/sbh_bucket_map.sv
sv/size_bucket_histogram.sv
test/size_bucket_histogram_checker.sv
test/testbench.sv
